### design/lzss_ring_decoder_core_defines.svh
// Assertion macros used by the LZSS ring decoder datapath.
`ifndef LZSS_RING_DECODER_CORE_DEFINES_SVH
`define LZSS_RING_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LRD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define LRD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/lrd_pkg.sv
// Types, constants and command/status structs of the LZSS ring decoder.
package lrd_pkg;

   localparam int RING_DEPTH = 4096;
   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam int CNT_W      = 24;
   localparam int LEN_W      = 5;
   localparam int LEN_BIAS   = 2;
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;

   localparam logic [CNT_W-1:0] CNT_MAX   = '1;
   localparam logic [CNT_W-1:0] CAP_RESET = '1;
   localparam logic             CSR_IDX_CAP = 1'b0;

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_DONE = 2'd1,
      KIND_BAD  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      PH_FLAG      = 2'd0,
      PH_TOKEN     = 2'd1,
      PH_MATCH_LOW = 2'd2
   } phase_type;

   typedef enum logic {
      SRC_ITEM = 1'b0,
      SRC_RING = 1'b1
   } dsrc_type;

   typedef struct packed {
      logic     take_item;
      logic     clr_stream;
      logic     clr_step;
      logic     count_in;
      logic     load_flags;
      logic     load_high;
      logic     copy_init;
      logic     copy_rd;
      logic     emit;
      kind_type kind;
      dsrc_type src;
      logic     last;
      logic     adv_token;
      logic     set_stop;
   } lrd_cmd_type;

   typedef struct packed {
      logic      stopped;
      phase_type phase;
      logic      flag_bit;
      logic      lit_over;
      logic      match_over;
      logic      pos_zero;
      logic      item_end;
      logic      copy_more;
      logic      clr_done;
      logic      slot_free;
   } lrd_stat_type;

endpackage

### design/lrd_channels.sv
// Valid/ready channel interfaces for compressed input and decoded results.
interface lrd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       stream_start;
   logic       stream_end;

   modport source (output valid, in_byte, stream_start, stream_end, input ready);
   modport sink   (input valid, in_byte, stream_start, stream_end, output ready);
endinterface

interface lrd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic [1:0]  kind;
   logic        last_of_run;
   logic [23:0] written_count;
   logic [23:0] consumed_count;

   modport source (output valid, out_byte, kind, last_of_run, written_count,
                   consumed_count, input ready);
   modport sink   (input valid, out_byte, kind, last_of_run, written_count,
                   consumed_count, output ready);
endinterface

### design/lrd_ctrl.sv
// Sequencer of the LZSS ring decoder: clearing pass, token decode, match copy.
module lrd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stream_start,
   output logic                 req_ready,
   input  lrd_pkg::lrd_stat_type stat,
   output lrd_pkg::lrd_cmd_type  cmd
);
   import lrd_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_STATUS
   } state_type;

   state_type state_ff, state_in;
   logic      pend_ff, pend_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   always_comb begin
      logic bad_now;
      bad_now   = 1'b0;
      cmd       = '0;
      state_in  = state_ff;
      pend_in   = pend_ff;
      req_ready = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_done) begin
               // A stream-start beat waits here until the ring is zeroed.
               state_in = pend_ff ? ST_EXEC : ST_IDLE;
               pend_in  = 1'b0;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take_item = 1'b1;
               if (req_stream_start) begin
                  cmd.clr_stream = 1'b1;
                  pend_in        = 1'b1;
                  state_in       = ST_CLEAR;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_EXEC: begin
            if (stat.stopped) begin
               state_in = ST_IDLE;
            end else if (stat.slot_free) begin
               cmd.count_in = 1'b1;
               state_in     = ST_IDLE;
               unique case (stat.phase)
                  PH_FLAG: begin
                     cmd.load_flags = 1'b1;
                     bad_now        = stat.item_end;
                  end
                  PH_TOKEN: begin
                     if (stat.flag_bit) begin
                        if (stat.lit_over) begin
                           bad_now = 1'b1;
                        end else begin
                           cmd.emit      = 1'b1;
                           cmd.kind      = KIND_DATA;
                           cmd.src       = SRC_ITEM;
                           cmd.last      = !stat.item_end;
                           cmd.adv_token = 1'b1;
                           if (stat.item_end) begin
                              state_in = ST_STATUS;
                           end
                        end
                     end else begin
                        cmd.load_high = 1'b1;
                        bad_now       = stat.item_end;
                     end
                  end
                  PH_MATCH_LOW: begin
                     if (stat.pos_zero) begin
                        cmd.emit     = 1'b1;
                        cmd.kind     = KIND_DONE;
                        cmd.last     = 1'b1;
                        cmd.set_stop = 1'b1;
                     end else if (stat.match_over) begin
                        bad_now = 1'b1;
                     end else begin
                        cmd.copy_init = 1'b1;
                        state_in      = ST_COPY_RD;
                     end
                  end
                  default: begin
                     bad_now = 1'b1;
                  end
               endcase
               if (bad_now) begin
                  cmd.emit     = 1'b1;
                  cmd.kind     = KIND_BAD;
                  cmd.last     = 1'b1;
                  cmd.set_stop = 1'b1;
               end
            end
         end
         ST_COPY_RD: begin
            cmd.copy_rd = 1'b1;
            state_in    = ST_COPY_WR;
         end
         ST_COPY_WR: begin
            if (stat.slot_free) begin
               cmd.emit = 1'b1;
               cmd.kind = KIND_DATA;
               cmd.src  = SRC_RING;
               if (stat.copy_more) begin
                  cmd.copy_rd = 1'b1;
               end else begin
                  cmd.last      = !stat.item_end;
                  cmd.adv_token = 1'b1;
                  state_in      = stat.item_end ? ST_STATUS : ST_IDLE;
               end
            end
         end
         ST_STATUS: begin
            if (stat.slot_free) begin
               cmd.emit     = 1'b1;
               cmd.kind     = KIND_BAD;
               cmd.last     = 1'b1;
               cmd.set_stop = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### design/lrd_datapath.sv
// Datapath of the LZSS ring decoder: history ring, token state, counters, result register.
`include "lzss_ring_decoder_core_defines.svh"

module lrd_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  lrd_pkg::lrd_cmd_type       cmd,
   output lrd_pkg::lrd_stat_type      stat,
   input  logic [7:0]                 req_in_byte,
   input  logic                       req_stream_end,
   input  logic [lrd_pkg::CNT_W-1:0]  cap,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [7:0]                 rsp_out_byte,
   output logic [1:0]                 rsp_kind,
   output logic                       rsp_last_of_run,
   output logic [lrd_pkg::CNT_W-1:0]  rsp_written_count,
   output logic [lrd_pkg::CNT_W-1:0]  rsp_consumed_count
);
   import lrd_pkg::*;

   logic [7:0]         ring_mem [RING_DEPTH];

   logic [7:0]         byte_ff;
   logic               end_ff;
   logic [RING_AW-1:0] cursor_ff;
   logic [RING_AW-1:0] clr_addr_ff;
   logic [RING_AW-1:0] copy_addr_ff;
   logic [LEN_W-1:0]   copy_left_ff;
   phase_type          phase_ff;
   logic [7:0]         flags_ff;
   logic [2:0]         bit_idx_ff;
   logic [7:0]         high_ff;
   logic [CNT_W-1:0]   written_ff;
   logic [CNT_W-1:0]   consumed_ff;
   logic               stopped_ff;
   logic [7:0]         rd_ff;
   logic [7:0]         byp_byte_ff;
   logic               byp_ff;

   logic               ovalid_ff;
   logic [7:0]         obyte_ff;
   kind_type           okind_ff;
   logic               olast_ff;
   logic [CNT_W-1:0]   owr_ff;
   logic [CNT_W-1:0]   ocons_ff;

   logic [7:0]         ring_byte;
   logic [7:0]         data_byte;
   logic               emit_data;
   logic [CNT_W-1:0]   written_inc;
   logic [CNT_W-1:0]   consumed_inc;
   logic [RING_AW-1:0] pos;
   logic [LEN_W-1:0]   len;
   logic [CNT_W:0]     need;
   logic               ring_we;
   logic [RING_AW-1:0] ring_waddr;
   logic [7:0]         ring_wdata;
   logic               slot_free;

   // A copy byte read in the same cycle its address is written comes from the bypass.
   assign ring_byte    = byp_ff ? byp_byte_ff : rd_ff;
   assign data_byte    = (cmd.src == SRC_RING) ? ring_byte : byte_ff;
   assign emit_data    = cmd.emit && (cmd.kind == KIND_DATA);
   assign written_inc  = (written_ff == CNT_MAX) ? written_ff : written_ff + 1'b1;
   assign consumed_inc = (consumed_ff == CNT_MAX) ? consumed_ff : consumed_ff + 1'b1;
   assign pos          = {high_ff[RING_AW-9:0], byte_ff};
   assign len          = LEN_W'(high_ff[7:4]) + LEN_W'(LEN_BIAS);
   assign need         = (CNT_W+1)'(written_ff) + (CNT_W+1)'(len);
   assign slot_free    = !ovalid_ff || rsp_ready;

   always_comb begin
      ring_we    = 1'b0;
      ring_waddr = cursor_ff;
      ring_wdata = data_byte;
      if (cmd.clr_step) begin
         ring_we    = 1'b1;
         ring_waddr = clr_addr_ff;
         ring_wdata = '0;
      end else if (emit_data) begin
         ring_we = 1'b1;
      end
   end

   always_comb begin
      stat.stopped    = stopped_ff;
      stat.phase      = phase_ff;
      stat.flag_bit   = flags_ff[bit_idx_ff];
      stat.lit_over   = written_ff >= cap;
      stat.match_over = need > (CNT_W+1)'(cap);
      stat.pos_zero   = pos == '0;
      stat.item_end   = end_ff;
      stat.copy_more  = copy_left_ff != '0;
      stat.clr_done   = clr_addr_ff == '1;
      stat.slot_free  = slot_free;
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ring_waddr] <= ring_wdata;
      end
      if (cmd.copy_rd) begin
         rd_ff <= ring_mem[copy_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff    <= RING_AW'(1);
         clr_addr_ff  <= '0;
         copy_left_ff <= '0;
         phase_ff     <= PH_FLAG;
         flags_ff     <= '0;
         bit_idx_ff   <= '0;
         high_ff      <= '0;
         written_ff   <= '0;
         consumed_ff  <= '0;
         stopped_ff   <= 1'b0;
         ovalid_ff    <= 1'b0;
      end else begin
         if (cmd.clr_stream) begin
            cursor_ff   <= RING_AW'(1);
            clr_addr_ff <= '0;
            phase_ff    <= PH_FLAG;
            flags_ff    <= '0;
            bit_idx_ff  <= '0;
            high_ff     <= '0;
            written_ff  <= '0;
            consumed_ff <= '0;
            stopped_ff  <= 1'b0;
         end else begin
            if (cmd.clr_step) begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
            end
            if (cmd.count_in) begin
               consumed_ff <= consumed_inc;
            end
            if (cmd.load_flags) begin
               flags_ff   <= byte_ff;
               bit_idx_ff <= '0;
               phase_ff   <= PH_TOKEN;
            end
            if (cmd.load_high) begin
               high_ff  <= byte_ff;
               phase_ff <= PH_MATCH_LOW;
            end
            if (cmd.copy_init) begin
               copy_left_ff <= len;
            end
            if (cmd.copy_rd) begin
               copy_left_ff <= copy_left_ff - 1'b1;
            end
            if (emit_data) begin
               cursor_ff  <= cursor_ff + 1'b1;
               written_ff <= written_inc;
            end
            if (cmd.adv_token) begin
               if (bit_idx_ff == '1) begin
                  bit_idx_ff <= '0;
                  phase_ff   <= PH_FLAG;
               end else begin
                  bit_idx_ff <= bit_idx_ff + 1'b1;
                  phase_ff   <= PH_TOKEN;
               end
            end
            if (cmd.set_stop) begin
               stopped_ff <= 1'b1;
            end
         end
         if (cmd.emit) begin
            ovalid_ff <= 1'b1;
         end else if (rsp_ready) begin
            ovalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         byte_ff <= req_in_byte;
         end_ff  <= req_stream_end;
      end
      if (cmd.copy_init) begin
         copy_addr_ff <= pos;
      end else if (cmd.copy_rd) begin
         copy_addr_ff <= copy_addr_ff + 1'b1;
      end
      if (cmd.copy_rd) begin
         byp_ff      <= emit_data && (cursor_ff == copy_addr_ff);
         byp_byte_ff <= data_byte;
      end
      if (cmd.emit) begin
         obyte_ff <= emit_data ? data_byte : '0;
         okind_ff <= cmd.kind;
         olast_ff <= cmd.last;
         owr_ff   <= emit_data ? written_inc : written_ff;
         ocons_ff <= cmd.count_in ? consumed_inc : consumed_ff;
      end
   end

   assign rsp_valid          = ovalid_ff;
   assign rsp_out_byte       = obyte_ff;
   assign rsp_kind           = okind_ff;
   assign rsp_last_of_run    = olast_ff;
   assign rsp_written_count  = owr_ff;
   assign rsp_consumed_count = ocons_ff;

   `LRD_ASSERT_IMP(a_emit_slot_free, clock, reset, cmd.emit, (!ovalid_ff || rsp_ready), "result beat loaded over a beat not yet taken")
   `LRD_ASSERT_NXT(a_status_stops, clock, reset, cmd.emit && cmd.kind != KIND_DATA, stopped_ff, "status beat did not stop the stream")
   `LRD_ASSERT_IMP(a_copy_in_range, clock, reset, cmd.copy_rd, copy_left_ff != '0, "match copy read past its length")
   `LRD_ASSERT_IMP(a_ring_one_writer, clock, reset, cmd.clr_step, !emit_data, "clearing pass and decoded byte both write the ring")

endmodule

### design/lzss_ring_decoder_core.sv
// Top level of the LZSS ring decoder: channels, capacity register, sequencer and datapath.
//
//   channel | dir | handshake             | payload
//   req     | in  | valid / ready         | in_byte, stream_start, stream_end
//   rsp     | out | valid / ready         | out_byte, kind, last_of_run, counts
//   csr     | in  | psel, penable, pready | paddr, pwdata, pwrite -> prdata
//
// Each flag, match-high, stopped or literal byte is taken in the idle state and decoded in the execute state.
// A match then reads the ring one entry ahead, and copies one byte per cycle while rsp ready allows it,
// from the single read port of the 4096-entry history ring.
// After reset, and after each stream-start beat, a clearing pass zeroes all 4096 ring
// entries, one entry a cycle, while req_ready stays low.
// A low rsp ready holds the sequencer; one result register separates the channels.
module lzss_ring_decoder_core (
   input  logic                         clock,
   input  logic                         reset,
   lrd_req_if.sink                      req,
   lrd_rsp_if.source                    rsp,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [lrd_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [lrd_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [lrd_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready
);
   import lrd_pkg::*;

   logic [CNT_W-1:0] cap_ff;
   logic             csr_wr;
   logic             csr_hit;
   lrd_cmd_type      cmd;
   lrd_stat_type     stat;

   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[CSR_AW-1:2] == CSR_IDX_CAP;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_hit ? CSR_DW'(cap_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_wr && csr_hit) begin
         cap_ff <= csr_pwdata[CNT_W-1:0];
      end
   end

   lrd_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req.valid),
      .req_stream_start (req.stream_start),
      .req_ready        (req.ready),
      .stat             (stat),
      .cmd              (cmd)
   );

   lrd_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_in_byte        (req.in_byte),
      .req_stream_end     (req.stream_end),
      .cap                (cap_ff),
      .rsp_valid          (rsp.valid),
      .rsp_ready          (rsp.ready),
      .rsp_out_byte       (rsp.out_byte),
      .rsp_kind           (rsp.kind),
      .rsp_last_of_run    (rsp.last_of_run),
      .rsp_written_count  (rsp.written_count),
      .rsp_consumed_count (rsp.consumed_count)
   );

endmodule
